// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/hcd_pkg.sv -----
package hcd_pkg;

  localparam int MAX_FLOORS = 8;
  localparam int FLR_W      = 3;
  localparam int MODE_W     = 3;
  localparam int SCORE_W    = 8;

  typedef logic [MAX_FLOORS-1:0] floor_mask_t;
  typedef logic [FLR_W-1:0]      floor_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [SCORE_W-1:0]    score_t;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam mode_t MODE_IDLE = 3'd0;
  localparam mode_t MODE_OPEN = 3'd1;
  localparam mode_t MODE_UP   = 3'd2;
  localparam mode_t MODE_DOWN = 3'd3;

  localparam score_t SCORE_AT_FLOOR = 8'd0;
  localparam score_t SCORE_AHEAD    = 8'd1;
  localparam score_t SCORE_IDLE     = 8'd2;
  localparam score_t SCORE_PASSED   = 8'd3;
  localparam score_t SCORE_OPPOSITE = 8'd4;
  localparam score_t SCORE_NONE     = 8'hFF;

  // Outcome of scoring one call slot.
  typedef struct packed {
    logic take;   // some car may serve the call
    logic to_a;   // car A wins
  } hcd_verdict_t;

endpackage

// ----- rtl/hall_call_dispatcher_two_car.sv -----
// Two-car hall-call dispatcher.
// Input channel (in_valid / in_stall) carries an opcode and the car status:
// register a hall call, run a dispatch over all pending calls, or read and
// clear the car B assignment masks. Result channel (out_valid / out_stall)
// returns one result per transfer with the new assignments, the pending masks
// and, on a read, the car B masks.
// With no stall on the result channel, register, read and unused opcodes
// transfer their result in the cycle after accept.
// Dispatch scores one call slot per cycle through a single scoring unit,
// up calls then down calls over min(NUM_FLOORS, 8) floors each, and then
// presents the result.
// One item is in flight at a time: in_stall is high after accept until the
// result has been transferred, and the next item can be accepted in the
// cycle after the transfer.
// A stalled result holds its value and keeps the block busy.
// Reset clears the pending masks and the car B masks and returns the block
// to idle with no result showing.
`include "assert_macros.svh"

module hall_call_dispatcher_two_car
  import hcd_pkg::*;
#(
  parameter int NUM_FLOORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_call_floor,
  input  logic        in_call_down,
  input  logic [2:0]  in_a_mode,
  input  logic [2:0]  in_a_floor,
  input  logic [2:0]  in_b_mode,
  input  logic [2:0]  in_b_floor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_a_up_new,
  output logic [7:0]  out_a_down_new,
  output logic [7:0]  out_b_up_new,
  output logic [7:0]  out_b_down_new,
  output logic [7:0]  out_pending_up_out,
  output logic [7:0]  out_pending_down_out,
  output logic [7:0]  out_slave_up_out,
  output logic [7:0]  out_slave_down_out,
  output logic        out_slave_any
);

  localparam int SCAN_FLOORS = (NUM_FLOORS < MAX_FLOORS) ? NUM_FLOORS : MAX_FLOORS;
  localparam floor_t LAST_FLOOR = FLR_W'(SCAN_FLOORS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  floor_t      floor_r, floor_nxt;
  logic        dir_r, dir_nxt;
  mode_t       am_r, am_nxt, bm_r, bm_nxt;
  floor_t      af_r, af_nxt, bf_r, bf_nxt;
  floor_mask_t pend_up_r, pend_up_nxt, pend_dn_r, pend_dn_nxt;
  floor_mask_t acc_up_r, acc_up_nxt, acc_dn_r, acc_dn_nxt;
  floor_mask_t a_up_r, a_up_nxt, a_dn_r, a_dn_nxt;
  floor_mask_t b_up_r, b_up_nxt, b_dn_r, b_dn_nxt;
  floor_mask_t s_up_r, s_up_nxt, s_dn_r, s_dn_nxt;

  hcd_verdict_t verdict;
  logic         cur_bit;
  logic         floor_ok;

  hcd_score u_score (
    .a_mode     (am_r),
    .a_floor    (af_r),
    .b_mode     (bm_r),
    .b_floor    (bf_r),
    .slot_floor (floor_r),
    .slot_down  (dir_r),
    .verdict    (verdict)
  );

  assign cur_bit  = dir_r ? pend_dn_r[floor_r] : pend_up_r[floor_r];
  assign floor_ok = (SCAN_FLOORS == MAX_FLOORS) ? 1'b1
                                                : (in_call_floor < LAST_FLOOR + 3'd1);

  always_comb begin
    state_nxt   = state_r;
    floor_nxt   = floor_r;
    dir_nxt     = dir_r;
    am_nxt      = am_r;
    af_nxt      = af_r;
    bm_nxt      = bm_r;
    bf_nxt      = bf_r;
    pend_up_nxt = pend_up_r;
    pend_dn_nxt = pend_dn_r;
    acc_up_nxt  = acc_up_r;
    acc_dn_nxt  = acc_dn_r;
    a_up_nxt    = a_up_r;
    a_dn_nxt    = a_dn_r;
    b_up_nxt    = b_up_r;
    b_dn_nxt    = b_dn_r;
    s_up_nxt    = s_up_r;
    s_dn_nxt    = s_dn_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          am_nxt    = in_a_mode;
          af_nxt    = in_a_floor;
          bm_nxt    = in_b_mode;
          bf_nxt    = in_b_floor;
          a_up_nxt  = '0;
          a_dn_nxt  = '0;
          b_up_nxt  = '0;
          b_dn_nxt  = '0;
          s_up_nxt  = '0;
          s_dn_nxt  = '0;
          floor_nxt = '0;
          dir_nxt   = 1'b0;
          state_nxt = ST_DONE;
          case (in_opcode)
            OP_REGISTER: begin
              if (floor_ok) begin
                if (in_call_down) begin
                  pend_dn_nxt[in_call_floor] = 1'b1;
                end else begin
                  pend_up_nxt[in_call_floor] = 1'b1;
                end
              end
            end
            OP_DISPATCH: begin
              state_nxt = ST_SCAN;
            end
            OP_READ: begin
              s_up_nxt   = acc_up_r;
              s_dn_nxt   = acc_dn_r;
              acc_up_nxt = '0;
              acc_dn_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Hand the current slot to the winning car and drop it from pending.
        if (cur_bit && verdict.take) begin
          if (dir_r) begin
            pend_dn_nxt[floor_r] = 1'b0;
            if (verdict.to_a) begin
              a_dn_nxt[floor_r] = 1'b1;
            end else begin
              b_dn_nxt[floor_r]   = 1'b1;
              acc_dn_nxt[floor_r] = 1'b1;
            end
          end else begin
            pend_up_nxt[floor_r] = 1'b0;
            if (verdict.to_a) begin
              a_up_nxt[floor_r] = 1'b1;
            end else begin
              b_up_nxt[floor_r]   = 1'b1;
              acc_up_nxt[floor_r] = 1'b1;
            end
          end
        end
        // Advance: up slots first, then down slots.
        if (floor_r == LAST_FLOOR) begin
          floor_nxt = '0;
          dir_nxt   = 1'b1;
          if (dir_r) begin
            state_nxt = ST_DONE;
          end
        end else begin
          floor_nxt = floor_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_up_r <= '0;
      pend_dn_r <= '0;
      acc_up_r  <= '0;
      acc_dn_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      pend_up_r <= pend_up_nxt;
      pend_dn_r <= pend_dn_nxt;
      acc_up_r  <= acc_up_nxt;
      acc_dn_r  <= acc_dn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    floor_r <= floor_nxt;
    dir_r   <= dir_nxt;
    am_r    <= am_nxt;
    af_r    <= af_nxt;
    bm_r    <= bm_nxt;
    bf_r    <= bf_nxt;
    a_up_r  <= a_up_nxt;
    a_dn_r  <= a_dn_nxt;
    b_up_r  <= b_up_nxt;
    b_dn_r  <= b_dn_nxt;
    s_up_r  <= s_up_nxt;
    s_dn_r  <= s_dn_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = (state_r == ST_DONE);
  assign out_a_up_new         = a_up_r;
  assign out_a_down_new       = a_dn_r;
  assign out_b_up_new         = b_up_r;
  assign out_b_down_new       = b_dn_r;
  assign out_pending_up_out   = pend_up_r;
  assign out_pending_down_out = pend_dn_r;
  assign out_slave_up_out     = s_up_r;
  assign out_slave_down_out   = s_dn_r;
  assign out_slave_any        = |(s_up_r | s_dn_r);

  `ASSERT_IMP(a_busy_while_result, clk, rst_n, out_valid, in_stall)
  `ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_IMP(a_no_double_assign, clk, rst_n, out_valid,
              ((a_up_r & b_up_r) == '0) && ((a_dn_r & b_dn_r) == '0))
  `ASSERT_IMP(a_assigned_not_pending, clk, rst_n, out_valid,
              (((a_up_r | b_up_r) & pend_up_r) == '0) &&
              (((a_dn_r | b_dn_r) & pend_dn_r) == '0))
  `ASSERT_IMP(a_b_assign_in_acc, clk, rst_n, out_valid,
              ((b_up_r & ~acc_up_r) == '0) && ((b_dn_r & ~acc_dn_r) == '0))

endmodule

// ----- rtl/hcd_score.sv -----
module hcd_score
  import hcd_pkg::*;
(
  input  mode_t        a_mode,
  input  floor_t       a_floor,
  input  mode_t        b_mode,
  input  floor_t       b_floor,
  input  floor_t       slot_floor,
  input  logic         slot_down,
  output hcd_verdict_t verdict
);

  function automatic score_t car_score(mode_t mode, floor_t car_fl, floor_t fl,
                                       logic down);
    score_t s;
    s = SCORE_NONE;
    if (mode inside {MODE_IDLE, MODE_OPEN}) begin
      s = (car_fl == fl) ? SCORE_AT_FLOOR : SCORE_IDLE;
    end else if (mode inside {MODE_UP, MODE_DOWN}) begin
      if ((mode == MODE_DOWN) != down) begin
        s = SCORE_OPPOSITE;
      end else if (!down && (fl >= car_fl)) begin
        s = SCORE_AHEAD;
      end else if (down && (fl <= car_fl)) begin
        s = SCORE_AHEAD;
      end else begin
        s = SCORE_PASSED;
      end
    end
    return s;
  endfunction

  score_t sa, sb;
  floor_t da, db;

  assign sa = car_score(a_mode, a_floor, slot_floor, slot_down);
  assign sb = car_score(b_mode, b_floor, slot_floor, slot_down);
  assign da = (a_floor > slot_floor) ? a_floor - slot_floor : slot_floor - a_floor;
  assign db = (b_floor > slot_floor) ? b_floor - slot_floor : slot_floor - b_floor;

  // Defer when neither car is a useful candidate; ties go to the nearer car.
  assign verdict.take = !((sa >= SCORE_OPPOSITE) && (sb >= SCORE_OPPOSITE));
  assign verdict.to_a = (sa != sb) ? (sa < sb) : (da <= db);

endmodule

// ----- verif/hall_call_dispatcher_two_car_tb.sv -----
`timescale 1ns / 100ps

module hall_call_dispatcher_two_car_tb
  import hcd_pkg::*;
();

  localparam int NUM_FLOORS = 8;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam mode_t      MODE_EMERGENCY = 3'd4;
  localparam mode_t      MODE_RESERVED  = 3'd5;
  localparam mode_t      MODE_UNDEFINED = 3'd7;

  typedef struct {
    floor_mask_t a_up;
    floor_mask_t a_down;
    floor_mask_t b_up;
    floor_mask_t b_down;
    floor_mask_t pend_up;
    floor_mask_t pend_down;
    floor_mask_t b_up_acc;
    floor_mask_t b_down_acc;
    logic        b_any;
  } hall_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_REGISTER;
  floor_t      in_call_floor = '0;
  logic        in_call_down = 1'b0;
  mode_t       in_a_mode = MODE_IDLE;
  floor_t      in_a_floor = '0;
  mode_t       in_b_mode = MODE_IDLE;
  floor_t      in_b_floor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_a_up_new;
  logic [7:0]  out_a_down_new;
  logic [7:0]  out_b_up_new;
  logic [7:0]  out_b_down_new;
  logic [7:0]  out_pending_up_out;
  logic [7:0]  out_pending_down_out;
  logic [7:0]  out_slave_up_out;
  logic [7:0]  out_slave_down_out;
  logic        out_slave_any;

  // Predictor state: pending hall calls and car B assignment accumulators
  floor_mask_t calls_up = '0;
  floor_mask_t calls_down = '0;
  floor_mask_t car_b_up_acc = '0;
  floor_mask_t car_b_down_acc = '0;

  hall_result_t hall_results_q[$];
  hall_result_t got_exp;
  int           fail_count = 0;
  logic         quiet = 1'b0;
  int           stall_hold = 0;

  hall_call_dispatcher_two_car #(.NUM_FLOORS(NUM_FLOORS)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_call_floor        (in_call_floor),
    .in_call_down         (in_call_down),
    .in_a_mode            (in_a_mode),
    .in_a_floor           (in_a_floor),
    .in_b_mode            (in_b_mode),
    .in_b_floor           (in_b_floor),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_a_up_new         (out_a_up_new),
    .out_a_down_new       (out_a_down_new),
    .out_b_up_new         (out_b_up_new),
    .out_b_down_new       (out_b_down_new),
    .out_pending_up_out   (out_pending_up_out),
    .out_pending_down_out (out_pending_down_out),
    .out_slave_up_out     (out_slave_up_out),
    .out_slave_down_out   (out_slave_down_out),
    .out_slave_any        (out_slave_any)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic score_t rate_car(mode_t mode, floor_t car_fl, floor_t fl, logic down);
    case (mode)
      MODE_IDLE, MODE_OPEN: return (car_fl == fl) ? SCORE_AT_FLOOR : SCORE_IDLE;
      MODE_UP, MODE_DOWN: begin
        if ((mode == MODE_DOWN) != down) return SCORE_OPPOSITE;
        if (mode == MODE_UP) return (fl >= car_fl) ? SCORE_AHEAD : SCORE_PASSED;
        return (fl <= car_fl) ? SCORE_AHEAD : SCORE_PASSED;
      end
      default: return SCORE_NONE;
    endcase
  endfunction

  function automatic int floor_dist(floor_t a, floor_t b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Advance the predicted state by one accepted item and return its result
  function automatic hall_result_t model_hall_calls(logic [1:0] op, floor_t cf, logic cdown,
                                                     mode_t am, floor_t af, mode_t bm,
                                                     floor_t bf);
    hall_result_t r;
    floor_mask_t  mask;
    score_t       sa;
    score_t       sb;
    logic         to_a;
    r = '{default: '0};
    case (op)
      OP_REGISTER: begin
        if (int'(cf) < NUM_FLOORS) begin
          if (cdown) calls_down[cf] = 1'b1;
          else calls_up[cf] = 1'b1;
        end
      end
      OP_DISPATCH: begin
        for (int d = 0; d < 2; d++) begin
          mask = (d == 1) ? calls_down : calls_up;
          for (int fl = 0; fl < NUM_FLOORS; fl++) begin
            if (!mask[fl]) continue;
            sa = rate_car(am, af, floor_t'(fl), d == 1);
            sb = rate_car(bm, bf, floor_t'(fl), d == 1);
            // defer when neither car is a reasonable fit
            if (sa >= SCORE_OPPOSITE && sb >= SCORE_OPPOSITE) continue;
            if (sa != sb) to_a = sa < sb;
            else to_a = floor_dist(af, floor_t'(fl)) <= floor_dist(bf, floor_t'(fl));
            mask[fl] = 1'b0;
            if (to_a) begin
              if (d == 1) r.a_down[fl] = 1'b1;
              else r.a_up[fl] = 1'b1;
            end else if (d == 1) begin
              r.b_down[fl] = 1'b1;
              car_b_down_acc[fl] = 1'b1;
            end else begin
              r.b_up[fl] = 1'b1;
              car_b_up_acc[fl] = 1'b1;
            end
          end
          if (d == 1) calls_down = mask;
          else calls_up = mask;
        end
      end
      OP_READ: begin
        r.b_up_acc = car_b_up_acc;
        r.b_down_acc = car_b_down_acc;
        r.b_any = |(car_b_up_acc | car_b_down_acc);
        car_b_up_acc = '0;
        car_b_down_acc = '0;
      end
      default: ;
    endcase
    r.pend_up = calls_up;
    r.pend_down = calls_down;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mode_t pick_mode();
    if ($urandom_range(0, 99) < 85) return mode_t'($urandom_range(0, 4));
    return mode_t'($urandom_range(5, 7));
  endfunction

  function automatic floor_t pick_floor();
    return floor_t'($urandom_range(0, NUM_FLOORS - 1));
  endfunction

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= idle_len();
    end
  end

  task automatic check_mask(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %02h, actual %02h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Outputs and stall are stable at the falling edge; a transfer follows at the next rise
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (hall_results_q.size() == 0) begin
        $error("result transfer with no expected result waiting");
        fail_count++;
      end else begin
        got_exp = hall_results_q.pop_front();
        check_mask("out_a_up_new", got_exp.a_up, out_a_up_new);
        check_mask("out_a_down_new", got_exp.a_down, out_a_down_new);
        check_mask("out_b_up_new", got_exp.b_up, out_b_up_new);
        check_mask("out_b_down_new", got_exp.b_down, out_b_down_new);
        check_mask("out_pending_up_out", got_exp.pend_up, out_pending_up_out);
        check_mask("out_pending_down_out", got_exp.pend_down, out_pending_down_out);
        check_mask("out_slave_up_out", got_exp.b_up_acc, out_slave_up_out);
        check_mask("out_slave_down_out", got_exp.b_down_acc, out_slave_down_out);
        check_mask("out_slave_any", {7'd0, got_exp.b_any}, {7'd0, out_slave_any});
      end
    end
  end

  // Call at a rising edge; returns at a rising edge
  task automatic send_cmd(input logic [1:0] op, input floor_t cf, input logic cdown,
                          input mode_t am, input floor_t af, input mode_t bm, input floor_t bf);
    int gap;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_call_floor <= cf;
    in_call_down <= cdown;
    in_a_mode <= am;
    in_a_floor <= af;
    in_b_mode <= bm;
    in_b_floor <= bf;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    hall_results_q.push_back(model_hall_calls(op, cf, cdown, am, af, bm, bf));
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic register_call(input floor_t cf, input logic cdown);
    send_cmd(OP_REGISTER, cf, cdown, pick_mode(), pick_floor(), pick_mode(), pick_floor());
  endtask

  task automatic dispatch(input mode_t am, input floor_t af, input mode_t bm, input floor_t bf);
    send_cmd(OP_DISPATCH, pick_floor(), 1'($urandom_range(0, 1)), am, af, bm, bf);
  endtask

  task automatic read_back();
    send_cmd(OP_READ, pick_floor(), 1'($urandom_range(0, 1)), pick_mode(), pick_floor(),
             pick_mode(), pick_floor());
  endtask

  // Drop valid and hold until every expected result has transferred;
  // an empty queue means valid is already low
  task automatic wait_results_drained();
    if (hall_results_q.size() != 0) begin
      in_valid <= 1'b0;
      while (hall_results_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_register_and_unused();
    read_back();
    send_cmd(OP_UNUSED, 3'd0, 1'b0, MODE_IDLE, 3'd0, MODE_IDLE, 3'd0);
    register_call(3'd0, 1'b0);
    register_call(3'd7, 1'b1);
    register_call(3'd7, 1'b0);
    register_call(3'd0, 1'b1);
    send_cmd(OP_UNUSED, 3'd7, 1'b1, MODE_UNDEFINED, 3'd7, MODE_UNDEFINED, 3'd7);
  endtask

  task automatic test_dispatch_scores();
    // unavailable cars: everything stays pending
    dispatch(MODE_EMERGENCY, 3'd0, MODE_EMERGENCY, 3'd7);
    dispatch(MODE_UNDEFINED, 3'd3, MODE_RESERVED, 3'd4);
    // ahead, passed and opposite scores split the corner calls
    dispatch(MODE_DOWN, 3'd0, MODE_UP, 3'd7);
    register_call(3'd3, 1'b0);
    dispatch(MODE_IDLE, 3'd3, MODE_IDLE, 3'd5);
    // equal idle scores at equal distance go to car A
    register_call(3'd3, 1'b0);
    dispatch(MODE_IDLE, 3'd1, MODE_OPEN, 3'd5);
    // equal scores, car B nearer
    register_call(3'd3, 1'b0);
    dispatch(MODE_IDLE, 3'd0, MODE_OPEN, 3'd4);
    // both cars moving the wrong way defer, then an idle car takes it
    register_call(3'd4, 1'b1);
    dispatch(MODE_UP, 3'd2, MODE_UP, 3'd6);
    dispatch(MODE_OPEN, 3'd4, MODE_EMERGENCY, 3'd4);
    read_back();
    read_back();
  endtask

  task automatic test_random_traffic(input int n_items);
    int   sent;
    int   burst;
    logic drained_once;
    sent = 0;
    drained_once = 1'b0;
    while (sent < n_items) begin
      quiet = (sent >= n_items / 3 && sent < n_items / 3 + 80);
      if (!drained_once && sent >= n_items / 2) begin
        wait_results_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        burst = $urandom_range(1, 6);
        repeat (burst) register_call(pick_floor(), 1'($urandom_range(0, 1)));
        dispatch(pick_mode(), pick_floor(), pick_mode(), pick_floor());
        sent += burst + 1;
        if ($urandom_range(0, 3) == 0) begin
          read_back();
          sent++;
        end
      end else begin
        send_cmd(2'($urandom_range(0, 3)), pick_floor(), 1'($urandom_range(0, 1)),
                 mode_t'($urandom_range(0, 7)), pick_floor(),
                 mode_t'($urandom_range(0, 7)), pick_floor());
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_register_and_unused();
    test_dispatch_scores();
    test_random_traffic(550);
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
